### hw/rtl/biq_pkg.sv
// Shared types and constants for the biquad filter unit.
`timescale 1ns / 1ps
package biq_pkg;
	localparam int SAMPLE_W = 16;
	localparam int COEF_W = 20;
	localparam int HIST_W = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 20;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [HIST_W-1:0] hist_t;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_A0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_A1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_A2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B2 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 3'd5;

	localparam coef_t COEF_A0_RESET = 20'sd65536;

	localparam int HIST_MAX = 8388607;
	localparam int HIST_MIN = -8388608;
	localparam int SAMPLE_MAX = 32767;
	localparam int SAMPLE_MIN = -32768;

	typedef struct packed {
		coef_t a0;
		coef_t a1;
		coef_t a2;
		coef_t b1;
		coef_t b2;
		logic  enable;
	} biq_cfg_t;
endpackage

### hw/rtl/biquad_iir_filter_unit.sv
// An accepted sample passes the input register, one MAC pass and the output
// register; one sample per cycle unless out_valid is held with out_ready low.
// If enabled, feedback history updates at the same edge as the output register.
// Reset (arst_n low): coefficients to unity pass (a0 = 1.0, rest 0), filter
// disabled, history cleared, both pipeline registers empty.
`timescale 1ns / 1ps
module biquad_iir_filter_unit #(
	parameter int COEF_FRAC_BITS = 16,
	parameter int HIST_FRAC_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [biq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [biq_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  biq_pkg::sample_t               in_sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output biq_pkg::sample_t               out_sample
);
	import biq_pkg::*;

	biq_cfg_t cfg;

	logic    valid_s1;
	sample_t sample_s1;
	logic    out_valid_q;
	sample_t out_sample_q;

	sample_t x1_q, x2_q;
	hist_t   y1_q, y2_q;

	sample_t y_out;
	hist_t   y_hist;
	logic    s1_fire;
	logic    in_fire;

	biq_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg          (cfg)
	);

	biq_datapath #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.HIST_FRAC_BITS (HIST_FRAC_BITS)
	) u_dp (
		.cfg    (cfg),
		.x0     (sample_s1),
		.x1     (x1_q),
		.x2     (x2_q),
		.y1     (y1_q),
		.y2     (y2_q),
		.y_out  (y_out),
		.y_hist (y_hist)
	);

	assign s1_fire = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_fire;
	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s1_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_s1 <= in_sample;
		end
		if (s1_fire) begin
			out_sample_q <= cfg.enable ? y_out : sample_s1;
		end
	end

	// history is frozen in bypass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (s1_fire && cfg.enable) begin
			x2_q <= x1_q;
			x1_q <= sample_s1;
			y2_q <= y1_q;
			y1_q <= y_hist;
		end
	end

	assign out_valid = out_valid_q;
	assign out_sample = out_sample_q;
endmodule

### hw/rtl/biq_cfg_regs.sv
// Configuration register file: coefficients and filter enable.
`timescale 1ns / 1ps
module biq_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write_en,
	input  logic [biq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [biq_pkg::CFG_DATA_W-1:0] cfg_data,
	output biq_pkg::biq_cfg_t            cfg
);
	import biq_pkg::*;

	biq_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.a0     <= COEF_A0_RESET;
			cfg_q.a1     <= '0;
			cfg_q.a2     <= '0;
			cfg_q.b1     <= '0;
			cfg_q.b2     <= '0;
			cfg_q.enable <= 1'b0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_COEF_A0: begin
					cfg_q.a0 <= coef_t'(cfg_data[COEF_W-1:0]);
				end
				REG_COEF_A1: begin
					cfg_q.a1 <= coef_t'(cfg_data[COEF_W-1:0]);
				end
				REG_COEF_A2: begin
					cfg_q.a2 <= coef_t'(cfg_data[COEF_W-1:0]);
				end
				REG_COEF_B1: begin
					cfg_q.b1 <= coef_t'(cfg_data[COEF_W-1:0]);
				end
				REG_COEF_B2: begin
					cfg_q.b2 <= coef_t'(cfg_data[COEF_W-1:0]);
				end
				REG_FILTER_ENABLE: begin
					cfg_q.enable <= cfg_data[0];
				end
				default: begin
					// unmapped index: write dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

### hw/rtl/biq_datapath.sv
// Direct form I multiply-accumulate with truncation and saturation.
`timescale 1ns / 1ps
module biq_datapath #(
	parameter int COEF_FRAC_BITS = 16,
	parameter int HIST_FRAC_BITS = 8
) (
	input  biq_pkg::biq_cfg_t cfg,
	input  biq_pkg::sample_t  x0,
	input  biq_pkg::sample_t  x1,
	input  biq_pkg::sample_t  x2,
	input  biq_pkg::hist_t    y1,
	input  biq_pkg::hist_t    y2,
	output biq_pkg::sample_t  y_out,
	output biq_pkg::hist_t    y_hist
);
	import biq_pkg::*;

	localparam int PFF_W = COEF_W + SAMPLE_W;
	localparam int FF_W = PFF_W + 2;
	localparam int FB_W = COEF_W + HIST_W;
	localparam int SH_W = FF_W + HIST_FRAC_BITS;
	localparam int ACC_W = ((SH_W > FB_W) ? SH_W : FB_W) + 2;
	localparam int OUT_SHIFT = COEF_FRAC_BITS + HIST_FRAC_BITS;

	localparam logic signed [ACC_W-1:0] HMAX = ACC_W'(HIST_MAX);
	localparam logic signed [ACC_W-1:0] HMIN = ACC_W'(HIST_MIN);
	localparam logic signed [ACC_W-1:0] SMAX = ACC_W'(SAMPLE_MAX);
	localparam logic signed [ACC_W-1:0] SMIN = ACC_W'(SAMPLE_MIN);

	logic signed [PFF_W-1:0] p_a0, p_a1, p_a2;
	logic signed [FB_W-1:0]  p_b1, p_b2;
	logic signed [FF_W-1:0]  ff;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] hist_biased, out_biased;
	logic signed [ACC_W-1:0] hist_q, out_q;

	assign p_a0 = cfg.a0 * x0;
	assign p_a1 = cfg.a1 * x1;
	assign p_a2 = cfg.a2 * x2;
	assign p_b1 = cfg.b1 * y1;
	assign p_b2 = cfg.b2 * y2;

	assign ff = FF_W'(p_a0) + FF_W'(p_a1) + FF_W'(p_a2);
	assign acc = (ACC_W'(ff) <<< HIST_FRAC_BITS) - ACC_W'(p_b1) - ACC_W'(p_b2);

	// negative values get 2^n-1 added so the arithmetic shift rounds toward zero
	assign hist_biased = acc + $signed({{(ACC_W-COEF_FRAC_BITS){1'b0}},
		{COEF_FRAC_BITS{acc[ACC_W-1]}}});
	assign out_biased = acc + $signed({{(ACC_W-OUT_SHIFT){1'b0}},
		{OUT_SHIFT{acc[ACC_W-1]}}});

	assign hist_q = hist_biased >>> COEF_FRAC_BITS;
	assign out_q = out_biased >>> OUT_SHIFT;

	always_comb begin
		if (hist_q > HMAX) begin
			y_hist = hist_t'(HMAX[HIST_W-1:0]);
		end else if (hist_q < HMIN) begin
			y_hist = hist_t'(HMIN[HIST_W-1:0]);
		end else begin
			y_hist = hist_t'(hist_q[HIST_W-1:0]);
		end
	end

	always_comb begin
		if (out_q > SMAX) begin
			y_out = sample_t'(SMAX[SAMPLE_W-1:0]);
		end else if (out_q < SMIN) begin
			y_out = sample_t'(SMIN[SAMPLE_W-1:0]);
		end else begin
			y_out = sample_t'(out_q[SAMPLE_W-1:0]);
		end
	end
endmodule
